FILE: src/alee_pkg.sv
// shared types and constants for the array list edit engine
// no dependencies; imported by alee_ram and array_list_edit_engine
package alee_pkg;

  localparam int SLOT_W = 4;
  localparam int VAL_W  = 32;
  localparam int REQ_W  = 3;
  localparam int STAT_W = 2;

  typedef enum logic [REQ_W-1:0] {
    REQ_INSERT  = 3'd0,
    REQ_DELETE  = 3'd1,
    REQ_REVERSE = 3'd2,
    REQ_SEARCH  = 3'd3,
    REQ_DISPLAY = 3'd4
  } req_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK       = 2'd0,
    STAT_BADPOS   = 2'd1,
    STAT_NOTFOUND = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INS_MV,
    ST_INS_PUT,
    ST_DEL_MV,
    ST_DEL_CLR,
    ST_REV_RA,
    ST_REV_RB,
    ST_REV_WA,
    ST_REV_WB,
    ST_SRCH,
    ST_DSP_OUT,
    ST_RESP
  } state_e;

endpackage

FILE: src/alee_ram.sv
// entry store: one write port, one registered read port, per-entry valid bits
// depends on alee_pkg; entries never written read as zero
module alee_ram
  import alee_pkg::*;
#(
  parameter int DEPTH = 8
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [VAL_W-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [VAL_W-1:0]         rdata_o
);

  logic [VAL_W-1:0] mem_q [DEPTH];
  logic [DEPTH-1:0] vld_q;
  logic [VAL_W-1:0] rd_q;
  logic             rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rd_q <= mem_q[raddr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (we_i) begin
        vld_q[waddr_i] <= 1'b1;
      end
      if (re_i) begin
        rd_vld_q <= vld_q[raddr_i];
      end
    end
  end

  assign rdata_o = rd_vld_q ? rd_q : '0;

endmodule

FILE: src/array_list_edit_engine.sv
// array list edit engine: insert, delete, reverse, search and display on DEPTH words
// insert shifts entries up from the tail then writes; delete shifts down then clears the last
// a bad request goes straight to the response; display beats go out while the sink keeps up
// throughput: one request at a time, next accepted in the cycle after the last beat is loaded
// reset: all entries read zero right after reset via per-entry valid bits, no clearing pass
// depends on alee_pkg and alee_ram
module array_list_edit_engine
  import alee_pkg::*;
#(
  parameter int DEPTH = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request channel
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // slot [3:0], item_value [35:4], zero pad [39:36]
  input  logic [2:0]  s_axis_tuser,   // req_type [2:0]
  // result channel
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // status [1:0], found_slot [5:2], entry_value [37:6],
                                      // zero pad [39:38]
  output logic        m_axis_tlast    // last beat of the request
);

  localparam int AW = $clog2(DEPTH);
  localparam logic [AW-1:0] LAST    = AW'(DEPTH - 1);
  localparam logic [AW-1:0] LAST_M1 = AW'(DEPTH - 2);
  localparam logic [AW-1:0] HALF_M1 = AW'(DEPTH / 2 - 1);

  // request fields
  logic [REQ_W-1:0]  req_type;
  logic [SLOT_W-1:0] slot;
  logic [VAL_W-1:0]  item_value;
  logic              in_fire;
  logic              pos_ok;
  logic [31:0]       slot_m1;
  logic [AW-1:0]     k_in;

  assign req_type   = s_axis_tuser;
  assign slot       = s_axis_tdata[SLOT_W-1:0];
  assign item_value = s_axis_tdata[SLOT_W+VAL_W-1:SLOT_W];
  assign in_fire    = s_axis_tvalid && s_axis_tready;
  assign pos_ok     = (slot != '0) && (32'(slot) <= 32'(DEPTH));
  assign slot_m1    = 32'(slot) - 32'd1;
  assign k_in       = slot_m1[AW-1:0];   // zero-based position, meaningful only when pos_ok

  // sequencer state
  state_e            state_q, state_d;
  logic [AW-1:0]     idx_q, idx_d;       // walking entry index
  logic [AW-1:0]     k_q, k_d;           // insert target index
  logic [VAL_W-1:0]  val_q, val_d;       // request value, or swap temp during reverse
  status_e           st_q, st_d;         // pending single-beat status
  logic [SLOT_W-1:0] fslot_q, fslot_d;   // pending found position

  // output register
  logic              out_vld_q;
  logic [STAT_W-1:0] out_status_q;
  logic [SLOT_W-1:0] out_slot_q;
  logic [VAL_W-1:0]  out_val_q;
  logic              out_last_q;
  logic              out_free;
  logic              out_load;
  logic [STAT_W-1:0] out_status_d;
  logic [SLOT_W-1:0] out_slot_d;
  logic [VAL_W-1:0]  out_val_d;
  logic              out_last_d;

  // ram port
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [VAL_W-1:0]  ram_wdata;
  logic              ram_re;
  logic [AW-1:0]     ram_raddr;
  logic [VAL_W-1:0]  ram_rdata;

  // derived indexes
  logic [AW-1:0]     idx_inc;
  logic [AW-1:0]     idx_dec;
  logic [AW-1:0]     idx_mir;            // mirror index for reverse
  logic [31:0]       idx_pos;            // one-based position of idx_q

  assign idx_inc = idx_q + AW'(1);
  assign idx_dec = idx_q - AW'(1);
  assign idx_mir = LAST - idx_q;
  assign idx_pos = 32'(idx_q) + 32'd1;

  assign out_free      = !out_vld_q || m_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);

  alee_ram #(
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q   <= idx_d;
    k_q     <= k_d;
    val_q   <= val_d;
    st_q    <= st_d;
    fslot_q <= fslot_d;
    if (out_load) begin
      out_status_q <= out_status_d;
      out_slot_q   <= out_slot_d;
      out_val_q    <= out_val_d;
      out_last_q   <= out_last_d;
    end
  end

  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    k_d          = k_q;
    val_d        = val_q;
    st_d         = st_q;
    fslot_d      = fslot_q;
    ram_we       = 1'b0;
    ram_waddr    = idx_q;
    ram_wdata    = ram_rdata;
    ram_re       = 1'b0;
    ram_raddr    = idx_q;
    out_load     = 1'b0;
    out_status_d = STAT_OK;
    out_slot_d   = '0;
    out_val_d    = '0;
    out_last_d   = 1'b1;

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          val_d   = item_value;
          k_d     = k_in;
          fslot_d = '0;
          st_d    = STAT_OK;
          case (req_type)
            REQ_INSERT: begin
              if (!pos_ok) begin
                st_d    = STAT_BADPOS;
                state_d = ST_RESP;
              end else if (k_in == LAST) begin
                state_d = ST_INS_PUT;
              end else begin
                // shift from the tail downward
                ram_re    = 1'b1;
                ram_raddr = LAST_M1;
                idx_d     = LAST_M1;
                state_d   = ST_INS_MV;
              end
            end
            REQ_DELETE: begin
              if (!pos_ok) begin
                st_d    = STAT_BADPOS;
                state_d = ST_RESP;
              end else if (k_in == LAST) begin
                state_d = ST_DEL_CLR;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = k_in + AW'(1);
                idx_d     = k_in + AW'(1);
                state_d   = ST_DEL_MV;
              end
            end
            REQ_REVERSE: begin
              idx_d   = '0;
              state_d = ST_REV_RA;
            end
            REQ_SEARCH: begin
              ram_re    = 1'b1;
              ram_raddr = '0;
              idx_d     = '0;
              state_d   = ST_SRCH;
            end
            REQ_DISPLAY: begin
              ram_re    = 1'b1;
              ram_raddr = '0;
              idx_d     = '0;
              state_d   = ST_DSP_OUT;
            end
            default: begin
              st_d    = STAT_BADPOS;
              state_d = ST_RESP;
            end
          endcase
        end
      end

      // read data holds entry idx; it moves to idx+1 while idx-1 is fetched
      ST_INS_MV: begin
        ram_we    = 1'b1;
        ram_waddr = idx_inc;
        ram_wdata = ram_rdata;
        if (idx_q == k_q) begin
          state_d = ST_INS_PUT;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = idx_dec;
          idx_d     = idx_dec;
        end
      end

      ST_INS_PUT: begin
        ram_we    = 1'b1;
        ram_waddr = k_q;
        ram_wdata = val_q;
        st_d      = STAT_OK;
        state_d   = ST_RESP;
      end

      // read data holds entry idx; it moves to idx-1 while idx+1 is fetched
      ST_DEL_MV: begin
        ram_we    = 1'b1;
        ram_waddr = idx_dec;
        ram_wdata = ram_rdata;
        if (idx_q == LAST) begin
          state_d = ST_DEL_CLR;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = idx_inc;
          idx_d     = idx_inc;
        end
      end

      ST_DEL_CLR: begin
        ram_we    = 1'b1;
        ram_waddr = LAST;
        ram_wdata = '0;
        st_d      = STAT_OK;
        state_d   = ST_RESP;
      end

      // swap one pair: fetch front, fetch back, write front, write back
      ST_REV_RA: begin
        ram_re    = 1'b1;
        ram_raddr = idx_q;
        state_d   = ST_REV_RB;
      end

      ST_REV_RB: begin
        ram_re    = 1'b1;
        ram_raddr = idx_mir;
        val_d     = ram_rdata;
        state_d   = ST_REV_WA;
      end

      ST_REV_WA: begin
        ram_we    = 1'b1;
        ram_waddr = idx_q;
        ram_wdata = ram_rdata;
        state_d   = ST_REV_WB;
      end

      ST_REV_WB: begin
        ram_we    = 1'b1;
        ram_waddr = idx_mir;
        ram_wdata = val_q;
        if (idx_q == HALF_M1) begin
          st_d    = STAT_OK;
          state_d = ST_RESP;
        end else begin
          idx_d   = idx_inc;
          state_d = ST_REV_RA;
        end
      end

      // one compare per cycle, lowest position wins
      ST_SRCH: begin
        if (ram_rdata == val_q) begin
          st_d    = STAT_OK;
          fslot_d = idx_pos[SLOT_W-1:0];
          state_d = ST_RESP;
        end else if (idx_q == LAST) begin
          st_d    = STAT_NOTFOUND;
          fslot_d = '0;
          state_d = ST_RESP;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = idx_inc;
          idx_d     = idx_inc;
        end
      end

      // read data stays put until the beat is loaded
      ST_DSP_OUT: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_status_d = STAT_OK;
          out_slot_d   = idx_pos[SLOT_W-1:0];
          out_val_d    = ram_rdata;
          out_last_d   = (idx_q == LAST);
          if (idx_q == LAST) begin
            state_d = ST_IDLE;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = idx_inc;
            idx_d     = idx_inc;
          end
        end
      end

      ST_RESP: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_status_d = st_q;
          out_slot_d   = fslot_q;
          out_val_d    = '0;
          out_last_d   = 1'b1;
          state_d      = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = {2'b00, out_val_q, out_slot_q, out_status_q};

endmodule
